[sv/jes3_pkg.sv]
// Package for the 3x3 Jacobi eigenvector unit: sequencer states, multiply-step
// microprogram, index helpers and fixed-point rounding. No dependencies.
package jes3_pkg;

  localparam logic [0:0] CFG_THRESHOLD = 1'b0;
  localparam logic [0:0] CFG_LIMIT     = 1'b1;

  localparam logic [15:0] THRESHOLD_RESET = 16'd7;
  localparam logic [7:0]  LIMIT_RESET     = 8'd100;

  localparam logic signed [31:0] ONE_Q30   = 32'sh4000_0000;
  localparam logic [30:0]        ONE_Q30_U = 31'h4000_0000;

  localparam logic [5:0] SQRT_LAST = 6'd31;
  localparam logic [5:0] DIV_LAST  = 6'd60;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SELECT, ST_PREP, ST_SHIFT, ST_MAC,
    ST_SQRT_H, ST_DIV, ST_SQRT_C, ST_SQRT_S, ST_FINISH
  } state_t;

  typedef enum logic [4:0] {
    OP_UD, OP_UE, OP_C, OP_C2, OP_SN, OP_CC, OP_SS, OP_CS, OP_TCS, OP_CMS,
    OP_APP, OP_AQQ, OP_APQ, OP_ARP, OP_ARQ, OP_D, OP_VP, OP_VQ
  } op_t;

  typedef enum logic [3:0] {
    DST_ROOT, DST_CC, DST_SS, DST_CS, DST_TCS,
    DST_APP, DST_AQQ, DST_APQ, DST_ARP, DST_ARQ, DST_VP, DST_VQ
  } dst_t;

  typedef struct packed {
    op_t        op_a;
    op_t        op_b;
    logic       sub;
    logic       first;
    logic       wr;
    dst_t       dst;
    logic [1:0] row;
    logic       brk;
  } mac_uop_t;

  function automatic mac_uop_t uop(input op_t a, input op_t b, input logic sub,
                                   input logic first, input logic wr, input dst_t dst,
                                   input logic [1:0] row, input logic brk);
    mac_uop_t u;
    u.op_a  = a;
    u.op_b  = b;
    u.sub   = sub;
    u.first = first;
    u.wr    = wr;
    u.dst   = dst;
    u.row   = row;
    u.brk   = brk;
    return u;
  endfunction

  // steps 0-1 form the pivot square sum; steps 2-29 apply the rotation
  function automatic mac_uop_t mac_uop(input logic [4:0] step);
    mac_uop_t u;
    case (step)
      5'd0:  u = uop(OP_UD,  OP_UD,  1'b0, 1'b1, 1'b0, DST_ROOT, 2'd0, 1'b0);
      5'd1:  u = uop(OP_UE,  OP_UE,  1'b0, 1'b0, 1'b1, DST_ROOT, 2'd0, 1'b1);
      5'd2:  u = uop(OP_C,   OP_C,   1'b0, 1'b1, 1'b1, DST_CC,   2'd0, 1'b0);
      5'd3:  u = uop(OP_SN,  OP_SN,  1'b0, 1'b1, 1'b1, DST_SS,   2'd0, 1'b0);
      5'd4:  u = uop(OP_C,   OP_SN,  1'b0, 1'b1, 1'b1, DST_CS,   2'd0, 1'b0);
      5'd5:  u = uop(OP_C2,  OP_SN,  1'b0, 1'b1, 1'b1, DST_TCS,  2'd0, 1'b0);
      5'd6:  u = uop(OP_CC,  OP_APP, 1'b0, 1'b1, 1'b0, DST_APP,  2'd0, 1'b0);
      5'd7:  u = uop(OP_SS,  OP_AQQ, 1'b0, 1'b0, 1'b0, DST_APP,  2'd0, 1'b0);
      5'd8:  u = uop(OP_TCS, OP_APQ, 1'b1, 1'b0, 1'b1, DST_APP,  2'd0, 1'b0);
      5'd9:  u = uop(OP_SS,  OP_APP, 1'b0, 1'b1, 1'b0, DST_AQQ,  2'd0, 1'b0);
      5'd10: u = uop(OP_CC,  OP_AQQ, 1'b0, 1'b0, 1'b0, DST_AQQ,  2'd0, 1'b0);
      5'd11: u = uop(OP_TCS, OP_APQ, 1'b0, 1'b0, 1'b1, DST_AQQ,  2'd0, 1'b0);
      5'd12: u = uop(OP_CS,  OP_D,   1'b0, 1'b1, 1'b0, DST_APQ,  2'd0, 1'b0);
      5'd13: u = uop(OP_CMS, OP_APQ, 1'b0, 1'b0, 1'b1, DST_APQ,  2'd0, 1'b0);
      5'd14: u = uop(OP_C,   OP_ARP, 1'b0, 1'b1, 1'b0, DST_ARP,  2'd0, 1'b0);
      5'd15: u = uop(OP_SN,  OP_ARQ, 1'b1, 1'b0, 1'b1, DST_ARP,  2'd0, 1'b0);
      5'd16: u = uop(OP_SN,  OP_ARP, 1'b0, 1'b1, 1'b0, DST_ARQ,  2'd0, 1'b0);
      5'd17: u = uop(OP_C,   OP_ARQ, 1'b0, 1'b0, 1'b1, DST_ARQ,  2'd0, 1'b0);
      5'd18: u = uop(OP_C,   OP_VP,  1'b0, 1'b1, 1'b0, DST_VP,   2'd0, 1'b0);
      5'd19: u = uop(OP_SN,  OP_VQ,  1'b1, 1'b0, 1'b1, DST_VP,   2'd0, 1'b0);
      5'd20: u = uop(OP_SN,  OP_VP,  1'b0, 1'b1, 1'b0, DST_VQ,   2'd0, 1'b0);
      5'd21: u = uop(OP_C,   OP_VQ,  1'b0, 1'b0, 1'b1, DST_VQ,   2'd0, 1'b0);
      5'd22: u = uop(OP_C,   OP_VP,  1'b0, 1'b1, 1'b0, DST_VP,   2'd1, 1'b0);
      5'd23: u = uop(OP_SN,  OP_VQ,  1'b1, 1'b0, 1'b1, DST_VP,   2'd1, 1'b0);
      5'd24: u = uop(OP_SN,  OP_VP,  1'b0, 1'b1, 1'b0, DST_VQ,   2'd1, 1'b0);
      5'd25: u = uop(OP_C,   OP_VQ,  1'b0, 1'b0, 1'b1, DST_VQ,   2'd1, 1'b0);
      5'd26: u = uop(OP_C,   OP_VP,  1'b0, 1'b1, 1'b0, DST_VP,   2'd2, 1'b0);
      5'd27: u = uop(OP_SN,  OP_VQ,  1'b1, 1'b0, 1'b1, DST_VP,   2'd2, 1'b0);
      5'd28: u = uop(OP_SN,  OP_VP,  1'b0, 1'b1, 1'b0, DST_VQ,   2'd2, 1'b0);
      5'd29: u = uop(OP_C,   OP_VQ,  1'b0, 1'b0, 1'b1, DST_VQ,   2'd2, 1'b1);
      default: u = uop(OP_C, OP_C,   1'b0, 1'b1, 1'b0, DST_CC,   2'd0, 1'b1);
    endcase
    return u;
  endfunction

  // pair k: 0 -> (0,1), 1 -> (0,2), 2 -> (1,2)
  function automatic logic [2:0] pair_p(input logic [1:0] k);
    case (k)
      2'd2:    return 3'd1;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [2:0] pair_q(input logic [1:0] k);
    case (k)
      2'd0:    return 3'd1;
      default: return 3'd2;
    endcase
  endfunction

  // off-diagonal slot holding (r,p) and (r,q)
  function automatic logic [2:0] idx_rp(input logic [1:0] k);
    case (k)
      2'd0:    return 3'd4;
      default: return 3'd3;
    endcase
  endfunction

  function automatic logic [2:0] idx_rq(input logic [1:0] k);
    case (k)
      2'd2:    return 3'd4;
      default: return 3'd5;
    endcase
  endfunction

  function automatic logic [3:0] vec_idx(input logic [1:0] row, input logic [2:0] col);
    logic [3:0] base;
    case (row)
      2'd1:    base = 4'd3;
      2'd2:    base = 4'd6;
      default: base = 4'd0;
    endcase
    return base + {1'b0, col};
  endfunction

  // floor((x + 2^29) / 2^30)
  function automatic logic signed [37:0] round_q30(input logic signed [67:0] x);
    logic signed [67:0] y;
    y = x + 68'sd536870912;
    return 38'(y >>> 30);
  endfunction

  function automatic logic signed [31:0] sat_entry(input logic signed [37:0] r);
    if (r > 38'sh0_7FFF_FFFF)
      return 32'sh7FFF_FFFF;
    else if (r < -38'sh0_8000_0000)
      return 32'sh8000_0000;
    else
      return r[31:0];
  endfunction

  function automatic logic signed [31:0] sat_vec(input logic signed [37:0] r);
    if (r > 38'sh0_4000_0000)
      return ONE_Q30;
    else if (r < -38'sh0_4000_0000)
      return -ONE_Q30;
    else
      return r[31:0];
  endfunction

endpackage

[sv/jacobi_eigen_solver_3x3_unit.sv]
// Jacobi eigenvector unit for symmetric 3x3 matrices, top level.
// Depends on jes3_pkg for states, the multiply microprogram and rounding helpers.
//
// Takes one symmetric matrix item (Q16.16) and returns its eigenvector matrix
// (Q2.30, one eigenvector per column) and the rotation count. Each rotation runs
// on one shared multiplier, one bit-serial square root and one restoring divider:
// the select, prep and shift setup states, the pivot square sum, 3 x 32
// square-root steps, 61 divide steps and 28 multiply steps. s_tready is high
// only while the unit is idle. A finished item waits in the output register
// while the next one is taken.
module jacobi_eigen_solver_3x3_unit
  import jes3_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // entry_11, entry_22, entry_33, entry_12, entry_13, entry_23 (32 bits each)
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // vec_r0_c0 .. vec_r2_c2 row-major (32 bits each), rotations_done (8 bits)
  output logic [295:0] m_tdata
);

  state_t state, state_next;

  logic [15:0] threshold;
  logic [7:0]  limit;
  logic [7:0]  pass_cnt;
  logic [4:0]  step;
  logic        phase;
  logic [5:0]  cnt;
  logic        out_valid;
  logic        load_out;

  logic signed [31:0] w [6];
  logic signed [31:0] rot [9];
  logic signed [31:0] out_vec [9];
  logic [7:0]         out_cnt;

  logic [1:0] pick;
  logic signed [31:0] app, aqq, apq, arp, arq;
  logic signed [32:0] d;
  logic [30:0] ud, ue;
  logic        neg_sn;
  logic signed [31:0] c, sn, cc, ss, cs, tcs, vtmp;
  logic [31:0] h;
  logic [30:0] g;

  logic signed [67:0] prod, acc;
  logic [63:0] sq_v, sq_res, sq_bit;
  logic [31:0] rem;
  logic [60:0] num;
  logic [30:0] quo;

  // pivot search
  logic [31:0] mag [3];
  logic [31:0] best;
  logic [1:0]  sel_pick;
  logic        go;

  always_comb begin
    for (int k = 0; k < 3; k++)
      mag[k] = w[3 + k][31] ? 32'(-w[3 + k]) : 32'(w[3 + k]);
    best = mag[0];
    sel_pick = 2'd0;
    if (mag[1] >= best) begin
      best = mag[1];
      sel_pick = 2'd1;
    end
    if (mag[2] >= best) begin
      best = mag[2];
      sel_pick = 2'd2;
    end
    go = (({1'b0, pass_cnt} + 9'd1) < {1'b0, limit}) && (best > {16'd0, threshold});
  end

  // shared multiply-accumulate
  mac_uop_t u;
  logic signed [33:0] opa, opb;
  logic signed [67:0] acc_new;
  logic signed [37:0] rnd;
  logic signed [31:0] val_entry, val_vec;

  function automatic logic signed [33:0] operand(input op_t op);
    case (op)
      OP_UD:   return {3'b000, ud};
      OP_UE:   return {3'b000, ue};
      OP_C:    return 34'(c);
      OP_C2:   return {c[31], c, 1'b0};
      OP_SN:   return 34'(sn);
      OP_CC:   return 34'(cc);
      OP_SS:   return 34'(ss);
      OP_CS:   return 34'(cs);
      OP_TCS:  return 34'(tcs);
      OP_CMS:  return 34'(cc) - 34'(ss);
      OP_APP:  return 34'(app);
      OP_AQQ:  return 34'(aqq);
      OP_APQ:  return 34'(apq);
      OP_ARP:  return 34'(arp);
      OP_ARQ:  return 34'(arq);
      OP_D:    return 34'(d);
      OP_VP:   return 34'(rot[vec_idx(u.row, pair_p(pick))]);
      OP_VQ:   return 34'(rot[vec_idx(u.row, pair_q(pick))]);
      default: return 34'sd0;
    endcase
  endfunction

  always_comb begin
    u = mac_uop(step);
    opa = operand(u.op_a);
    opb = operand(u.op_b);
    acc_new = u.first ? (u.sub ? -prod : prod) : (u.sub ? acc - prod : acc + prod);
    rnd = round_q30(acc_new);
    val_entry = sat_entry(rnd);
    val_vec = sat_vec(rnd);
  end

  // square root step
  logic [63:0] sq_sum, sq_v_n, sq_res_n;
  logic        sq_ge;
  always_comb begin
    sq_sum = sq_res + sq_bit;
    sq_ge = sq_v >= sq_sum;
    sq_v_n = sq_ge ? sq_v - sq_sum : sq_v;
    sq_res_n = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;
  end

  // divide step
  logic [32:0] rem_sh;
  logic        dv_ge;
  logic [32:0] rem_n;
  logic [30:0] quo_n, g_n, half_c, half_s;
  always_comb begin
    rem_sh = {rem, num[60]};
    dv_ge = rem_sh >= {1'b0, h};
    rem_n = dv_ge ? rem_sh - {1'b0, h} : rem_sh;
    quo_n = {quo[29:0], dv_ge};
    g_n = (quo_n > ONE_Q30_U) ? ONE_Q30_U : quo_n;
    half_c = 31'(({1'b0, ONE_Q30_U} + {1'b0, g_n}) >> 1);
    half_s = 31'((ONE_Q30_U - g) >> 1);
  end

  // shift of the pivot magnitudes below 2^31
  logic [32:0] ud33, ue33, m33;
  always_comb begin
    ud33 = d[32] ? 33'(-d) : 33'(d);
    ue33 = {(apq[31] ? 32'(-apq) : 32'(apq)), 1'b0};
    m33 = (ud33 > ue33) ? ud33 : ue33;
  end

  // sequencer outputs
  always_comb begin
    s_tready = (state == ST_IDLE);
    load_out = (state == ST_FINISH) && (!out_valid || m_tready);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_SELECT;
      ST_SELECT: state_next = go ? ST_PREP : ST_FINISH;
      ST_PREP:   state_next = ST_SHIFT;
      ST_SHIFT:  state_next = ST_MAC;
      ST_MAC: begin
        if (phase && u.brk)
          state_next = (u.dst == DST_ROOT) ? ST_SQRT_H : ST_SELECT;
      end
      ST_SQRT_H: if (cnt == SQRT_LAST) state_next = ST_DIV;
      ST_DIV:    if (cnt == DIV_LAST) state_next = ST_SQRT_C;
      ST_SQRT_C: if (cnt == SQRT_LAST) state_next = ST_SQRT_S;
      ST_SQRT_S: if (cnt == SQRT_LAST) state_next = ST_MAC;
      ST_FINISH: if (load_out) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      threshold <= THRESHOLD_RESET;
      limit <= LIMIT_RESET;
      pass_cnt <= 8'd0;
      step <= 5'd0;
      phase <= 1'b0;
      cnt <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD: threshold <= cfg_data;
          CFG_LIMIT:     limit <= cfg_data[7:0];
          default:       ;
        endcase
      end
      if (s_tvalid && s_tready)
        pass_cnt <= 8'd0;
      else if (state == ST_MAC && phase && u.brk && u.dst != DST_ROOT)
        pass_cnt <= pass_cnt + 8'd1;
      if (state == ST_SHIFT)
        step <= 5'd0;
      else if (state == ST_MAC && phase)
        step <= step + 5'd1;
      phase <= (state == ST_MAC) ? !phase : 1'b0;
      if (state == ST_SQRT_H || state == ST_DIV || state == ST_SQRT_C || state == ST_SQRT_S)
        cnt <= (state_next != state) ? 6'd0 : cnt + 6'd1;
      else
        cnt <= 6'd0;
      if (load_out)
        out_valid <= 1'b1;
      else if (m_tready)
        out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          for (int i = 0; i < 6; i++)
            w[i] <= s_tdata[32*i +: 32];
          for (int i = 0; i < 9; i++)
            rot[i] <= (i % 4 == 0) ? ONE_Q30 : 32'sd0;
        end
      end
      ST_SELECT: pick <= sel_pick;
      ST_PREP: begin
        app <= w[pair_p(pick)];
        aqq <= w[pair_q(pick)];
        apq <= w[3'd3 + {1'b0, pick}];
        arp <= w[idx_rp(pick)];
        arq <= w[idx_rq(pick)];
        d <= 33'(w[pair_p(pick)]) - 33'(w[pair_q(pick)]);
      end
      ST_SHIFT: begin
        neg_sn <= (d != 33'sd0) && (apq != 32'sd0) && (d[32] == apq[31]);
        if (m33[32]) begin
          ud <= 31'(ud33 >> 2);
          ue <= 31'(ue33 >> 2);
        end else if (m33[31]) begin
          ud <= 31'(ud33 >> 1);
          ue <= 31'(ue33 >> 1);
        end else begin
          ud <= ud33[30:0];
          ue <= ue33[30:0];
        end
      end
      ST_MAC: begin
        if (!phase) begin
          prod <= 68'(opa * opb);
        end else begin
          acc <= acc_new;
          if (u.wr) begin
            case (u.dst)
              DST_ROOT: begin
                sq_v <= acc_new[63:0];
                sq_res <= 64'd0;
                sq_bit <= 64'd1 << 62;
              end
              DST_CC:  cc <= rnd[31:0];
              DST_SS:  ss <= rnd[31:0];
              DST_CS:  cs <= rnd[31:0];
              DST_TCS: tcs <= rnd[31:0];
              DST_APP: w[pair_p(pick)] <= val_entry;
              DST_AQQ: w[pair_q(pick)] <= val_entry;
              DST_APQ: w[3'd3 + {1'b0, pick}] <= val_entry;
              DST_ARP: w[idx_rp(pick)] <= val_entry;
              DST_ARQ: w[idx_rq(pick)] <= val_entry;
              DST_VP:  vtmp <= val_vec;
              DST_VQ: begin
                rot[vec_idx(u.row, pair_p(pick))] <= vtmp;
                rot[vec_idx(u.row, pair_q(pick))] <= val_vec;
              end
              default: ;
            endcase
          end
        end
      end
      ST_SQRT_H: begin
        sq_v <= sq_v_n;
        sq_res <= sq_res_n;
        sq_bit <= sq_bit >> 2;
        if (cnt == SQRT_LAST) begin
          h <= sq_res_n[31:0];
          rem <= 32'd0;
          num <= {ud, 30'd0};
          quo <= 31'd0;
        end
      end
      ST_DIV: begin
        rem <= rem_n[31:0];
        num <= {num[59:0], 1'b0};
        quo <= quo_n;
        if (cnt == DIV_LAST) begin
          g <= g_n;
          sq_v <= {3'b000, half_c, 30'd0};
          sq_res <= 64'd0;
          sq_bit <= 64'd1 << 62;
        end
      end
      ST_SQRT_C: begin
        if (cnt == SQRT_LAST) begin
          c <= sq_res_n[31:0];
          sq_v <= {3'b000, half_s, 30'd0};
          sq_res <= 64'd0;
          sq_bit <= 64'd1 << 62;
        end else begin
          sq_v <= sq_v_n;
          sq_res <= sq_res_n;
          sq_bit <= sq_bit >> 2;
        end
      end
      ST_SQRT_S: begin
        sq_v <= sq_v_n;
        sq_res <= sq_res_n;
        sq_bit <= sq_bit >> 2;
        if (cnt == SQRT_LAST)
          sn <= neg_sn ? -$signed(sq_res_n[31:0]) : $signed(sq_res_n[31:0]);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      for (int i = 0; i < 9; i++)
        out_vec[i] <= rot[i];
      out_cnt <= pass_cnt;
    end
  end

  always_comb begin
    m_tvalid = out_valid;
    for (int i = 0; i < 9; i++)
      m_tdata[32*i +: 32] = out_vec[i];
    m_tdata[295:288] = out_cnt;
  end

  a_sqrt_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT_H || state == ST_SQRT_C || state == ST_SQRT_S) |-> (cnt <= SQRT_LAST))
    else $error("square root ran past its last step");

  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (cnt <= DIV_LAST))
    else $error("divider ran past its last step");

  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC && step >= 5'd2) |-> (c <= ONE_Q30 && c >= 32'sd0))
    else $error("cosine out of range");

  a_pass_limit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PREP) |-> (({1'b0, pass_cnt} + 9'd1) < {1'b0, limit}))
    else $error("rotation started beyond the limit");

  a_accept_select: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_SELECT && pass_cnt == 8'd0))
    else $error("accepted item did not start a pivot search");

endmodule
